>>> design/packet_flow_hash_steering_top_assert.svh
// Assertion macros shared by the flow hash steering design.
`ifndef PACKET_FLOW_HASH_STEERING_TOP_ASSERT_SVH
`define PACKET_FLOW_HASH_STEERING_TOP_ASSERT_SVH

// A condition that must never hold at a clock edge outside reset.
`define PFH_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

// A condition that, when it holds, requires another in the same cycle.
`define PFH_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

>>> design/pfh_pkg.sv
// Package with the types, codes and constants of the flow hash steering design.
package pfh_pkg;

    // Field widths.
    localparam int HASH_W   = 32;
    localparam int KIND_W   = 2;
    localparam int BYTE_W   = 8;
    localparam int NOUT_W   = 9;
    localparam int PORT_W   = 8;
    localparam int TAG_W    = 3;
    localparam int L3_W     = 6;

    // Default sizes.
    localparam int MAX_VLAN_TAGS_DEF   = 4;
    localparam int MAX_FRAME_BYTES_DEF = 16383;
    localparam int QUEUE_DEPTH_DEF     = 4;

    // Ethernet and IP constants.
    localparam logic [15:0] ETYPE_VLAN = 16'h8100;
    localparam logic [15:0] ETYPE_IPV4 = 16'h0800;
    localparam logic [15:0] ETYPE_IPV6 = 16'h86DD;
    localparam int L2_HDR_BYTES = 14;
    localparam int V4_HDR_BYTES = 20;
    localparam int V6_HDR_BYTES = 40;
    localparam int VLAN_TAG_BYTES = 4;

    // Reset value of the output count register.
    localparam logic [NOUT_W-1:0] NUM_OUTPUTS_RST = 9'd2;
    localparam logic [NOUT_W-1:0] NUM_OUTPUTS_MAX = 9'd256;

    // Parser progress codes.
    localparam logic [KIND_W-1:0] PK_SEEK   = 2'd0;
    localparam logic [KIND_W-1:0] PK_V4     = 2'd1;
    localparam logic [KIND_W-1:0] PK_V6     = 2'd2;
    localparam logic [KIND_W-1:0] PK_NOHASH = 2'd3;

    // Reported frame kinds.
    localparam logic [KIND_W-1:0] FK_UNKNOWN = 2'd0;
    localparam logic [KIND_W-1:0] FK_V4      = 2'd1;
    localparam logic [KIND_W-1:0] FK_V6      = 2'd2;
    localparam logic [KIND_W-1:0] FK_TAGS    = 2'd3;

    // One classified frame, passed from the parser to the reduction unit.
    typedef struct packed {
        logic [HASH_W-1:0] hash;
        logic [KIND_W-1:0] kind;
    } pfh_rec_t;

endpackage

>>> design/pfh_parse.sv
// Front part: per-byte frame parser that builds the address-sum hash.
module pfh_parse
    import pfh_pkg::*;
#(
    parameter int MAX_VLAN_TAGS   = MAX_VLAN_TAGS_DEF,
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  logic [BYTE_W-1:0] frame_byte,
    input  logic              last_byte,
    output logic              rec_push,
    output pfh_rec_t          rec
);

    localparam int CNT_W = $clog2(MAX_FRAME_BYTES + 1);
    localparam int POS_W = CNT_W + 1;

    logic [CNT_W-1:0]  cnt_reg,  cnt_next;
    logic [15:0]       ts_reg,   ts_next;
    logic [L3_W-1:0]   l3_reg,   l3_next;
    logic [TAG_W-1:0]  tag_reg,  tag_next;
    logic [KIND_W-1:0] pk_reg,   pk_next;
    logic [HASH_W-1:0] wb_reg,   wb_next;
    logic [HASH_W-1:0] hs_reg,   hs_next;

    logic [POS_W-1:0]  pos;
    logic [POS_W-1:0]  l3w;
    logic [POS_W-1:0]  off;
    logic [POS_W-1:0]  cnt_end;
    logic [POS_W-1:0]  l3_end;
    logic              take;

    // Next-state logic for one accepted byte, and the end-of-frame record.
    always_comb
    begin
        cnt_next = cnt_reg;
        ts_next  = ts_reg;
        l3_next  = l3_reg;
        tag_next = tag_reg;
        pk_next  = pk_reg;
        wb_next  = wb_reg;
        hs_next  = hs_reg;
        rec_push = 1'b0;
        rec.hash = '0;
        rec.kind = FK_UNKNOWN;

        pos  = {1'b0, cnt_reg};
        l3w  = POS_W'(l3_reg);
        off  = pos - l3w;
        take = accept && (cnt_reg < CNT_W'(MAX_FRAME_BYTES));

        if (take)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (pk_reg == PK_SEEK)
            begin
                // Shift in the bytes that may hold the ethertype.
                if ((pos + POS_W'(2)) >= l3w)
                begin
                    ts_next = {ts_reg[7:0], frame_byte};
                    if ((pos + POS_W'(1)) == l3w)
                    begin
                        if (ts_next == ETYPE_VLAN)
                        begin
                            if (tag_reg >= TAG_W'(MAX_VLAN_TAGS))
                            begin
                                pk_next = PK_NOHASH;
                            end
                            else
                            begin
                                tag_next = tag_reg + 1'b1;
                                l3_next  = l3_reg + L3_W'(VLAN_TAG_BYTES);
                            end
                        end
                        else if (ts_next == ETYPE_IPV4)
                        begin
                            pk_next = PK_V4;
                        end
                        else if (ts_next == ETYPE_IPV6)
                        begin
                            pk_next = PK_V6;
                        end
                        else
                        begin
                            pk_next = PK_NOHASH;
                        end
                    end
                end
            end
            else if (pos >= l3w)
            begin
                // Gather address words and add each finished one.
                if (pk_reg == PK_V4 && off >= POS_W'(12) && off <= POS_W'(19))
                begin
                    wb_next = {wb_reg[HASH_W-9:0], frame_byte};
                    if (off[1:0] == 2'd3)
                    begin
                        hs_next = hs_reg + wb_next;
                    end
                end
                else if (pk_reg == PK_V6 && off >= POS_W'(8) && off <= POS_W'(39))
                begin
                    wb_next = {frame_byte, wb_reg[HASH_W-1:8]};
                    if (off[1:0] == 2'd3)
                    begin
                        hs_next = hs_reg + wb_next;
                    end
                end
            end
        end

        cnt_end = {1'b0, cnt_next};
        l3_end  = POS_W'(l3_next);

        // On the last byte, classify the frame and restart the parser.
        if (accept && last_byte)
        begin
            rec_push = 1'b1;
            if (pk_next == PK_V4 && cnt_end >= l3_end + POS_W'(V4_HDR_BYTES))
            begin
                rec.hash = hs_next;
                rec.kind = FK_V4;
            end
            else if (pk_next == PK_V6 && cnt_end >= l3_end + POS_W'(V6_HDR_BYTES))
            begin
                rec.hash = hs_next;
                rec.kind = FK_V6;
            end
            else if (pk_next == PK_NOHASH && ts_next == ETYPE_VLAN)
            begin
                rec.kind = FK_TAGS;
            end
            cnt_next = '0;
            ts_next  = '0;
            l3_next  = L3_W'(L2_HDR_BYTES);
            tag_next = '0;
            pk_next  = PK_SEEK;
            wb_next  = '0;
            hs_next  = '0;
        end
    end

    // Parser state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            ts_reg  <= '0;
            l3_reg  <= L3_W'(L2_HDR_BYTES);
            tag_reg <= '0;
            pk_reg  <= PK_SEEK;
            wb_reg  <= '0;
            hs_reg  <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            ts_reg  <= ts_next;
            l3_reg  <= l3_next;
            tag_reg <= tag_next;
            pk_reg  <= pk_next;
            wb_reg  <= wb_next;
            hs_reg  <= hs_next;
        end
    end

endmodule

>>> design/pfh_fifo.sv
// Short queue of classified frames between the parser and the reduction unit.
module pfh_fifo
    import pfh_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     wr_en,
    input  pfh_rec_t wr_rec,
    output logic     full,
    input  logic     rd_en,
    output pfh_rec_t rd_rec,
    output logic     empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pfh_rec_t         mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_wr;
    logic             do_rd;

    assign full   = (count_reg == CNT_W'(DEPTH));
    assign empty  = (count_reg == '0);
    assign do_wr  = wr_en && !full;
    assign do_rd  = rd_en && !empty;
    assign rd_rec = mem_reg[rd_ptr_reg];

    // Pointer and fill count updates, with wrap at the queue depth.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_rec;
        end
    end

endmodule

>>> design/pfh_reduce.sv
// Back part: bit-serial hash modulo output count, with the result register.
module pfh_reduce
    import pfh_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [NOUT_W-1:0] num_eff,
    input  logic              q_empty,
    input  pfh_rec_t          q_rec,
    output logic              q_pop,
    output logic              empty,
    input  logic              pop,
    output logic [PORT_W-1:0] out_port,
    output logic [HASH_W-1:0] flow_hash,
    output logic [KIND_W-1:0] frame_kind
);

    localparam int STEP_W = $clog2(HASH_W);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    logic [1:0]        state_reg, state_next;
    logic [STEP_W-1:0] step_reg,  step_next;
    logic [HASH_W-1:0] quo_reg,   quo_next;
    logic [PORT_W-1:0] rem_reg,   rem_next;
    logic [HASH_W-1:0] hash_reg,  hash_next;
    logic [KIND_W-1:0] kind_reg,  kind_next;
    logic              vld_reg,   vld_next;
    logic [PORT_W-1:0] port_o_reg, port_o_next;
    logic [HASH_W-1:0] hash_o_reg, hash_o_next;
    logic [KIND_W-1:0] kind_o_reg, kind_o_next;
    logic [NOUT_W-1:0] trial;

    assign empty      = !vld_reg;
    assign out_port   = port_o_reg;
    assign flow_hash  = hash_o_reg;
    assign frame_kind = kind_o_reg;

    // Sequencer: take a frame, run one remainder step per cycle, then present it.
    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        quo_next    = quo_reg;
        rem_next    = rem_reg;
        hash_next   = hash_reg;
        kind_next   = kind_reg;
        vld_next    = vld_reg;
        port_o_next = port_o_reg;
        hash_o_next = hash_o_reg;
        kind_o_next = kind_o_reg;
        q_pop       = 1'b0;
        trial       = {rem_reg, quo_reg[HASH_W-1]};

        if (vld_reg && pop)
        begin
            vld_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop      = 1'b1;
                    quo_next   = q_rec.hash;
                    hash_next  = q_rec.hash;
                    kind_next  = q_rec.kind;
                    rem_next   = '0;
                    step_next  = '0;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                quo_next = {quo_reg[HASH_W-2:0], 1'b0};
                if (trial >= num_eff)
                begin
                    rem_next = PORT_W'(trial - num_eff);
                end
                else
                begin
                    rem_next = PORT_W'(trial);
                end
                if (step_reg == STEP_W'(HASH_W - 1))
                begin
                    state_next = ST_HOLD;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_HOLD:
            begin
                if (!vld_reg || pop)
                begin
                    vld_next    = 1'b1;
                    port_o_next = rem_reg;
                    hash_o_next = hash_reg;
                    kind_o_next = kind_reg;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            vld_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            vld_reg   <= vld_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        quo_reg    <= quo_next;
        rem_reg    <= rem_next;
        hash_reg   <= hash_next;
        kind_reg   <= kind_next;
        port_o_reg <= port_o_next;
        hash_o_reg <= hash_o_next;
        kind_o_reg <= kind_o_next;
    end

endmodule

>>> design/packet_flow_hash_steering_top.sv
// Top level of the flow hash steering block: config register, parser, queue, reducer.
//
// Usage: frame bytes enter in wire order on the input queue port. A byte is
// transferred at a clock edge with push high and full low; last_byte marks
// the final byte of a frame. Each frame yields one result on the output
// queue port: flow_hash (symmetric IPv4/IPv6 address sum), frame_kind and
// out_port = flow_hash modulo num_outputs (0 acts as 1, capped at 256). A
// result is transferred at an edge with pop high and empty low. The parser
// takes one byte per cycle while the queue is not full. After the last
// byte, the record is written into the frame queue, loaded into the
// remainder unit, reduced bit-serially (one hash bit per cycle) and moved
// into the output register. The remainder unit takes a new frame only once
// its result is in the output register; a four-entry frame queue absorbs
// bursts of short frames, and full rises when it is occupied to the brim.
// If the receiver does not pop, the finished result stays in the output
// register, the remainder unit holds its next result, and the queue fills
// until full stops the sender. Reset clears all control state, empties the
// queue and sets num_outputs to 2. num_outputs is written through cfg_we
// and cfg_data and may only change while no frame is in flight.
`include "packet_flow_hash_steering_top_assert.svh"

module packet_flow_hash_steering_top
    import pfh_pkg::*;
#(
    parameter int MAX_VLAN_TAGS   = MAX_VLAN_TAGS_DEF,
    parameter int MAX_FRAME_BYTES = MAX_FRAME_BYTES_DEF,
    parameter int QUEUE_DEPTH     = QUEUE_DEPTH_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [BYTE_W-1:0] frame_byte,
    input  logic              last_byte,
    output logic              empty,
    input  logic              pop,
    output logic [PORT_W-1:0] out_port,
    output logic [HASH_W-1:0] flow_hash,
    output logic [KIND_W-1:0] frame_kind,
    input  logic              cfg_we,
    input  logic [NOUT_W-1:0] cfg_data
);

    logic [NOUT_W-1:0] num_outputs_reg;
    logic [NOUT_W-1:0] num_eff;
    logic              accept;
    logic              fifo_push;
    logic              fifo_full;
    logic              fifo_pop;
    logic              fifo_empty;
    logic              unhashed;
    pfh_rec_t          push_rec;
    pfh_rec_t          pop_rec;

    // Output count register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_outputs_reg <= NUM_OUTPUTS_RST;
        end
        else if (cfg_we)
        begin
            num_outputs_reg <= cfg_data;
        end
    end

    // Zero acts as one output, and counts above the maximum saturate.
    always_comb
    begin
        if (num_outputs_reg == '0)
        begin
            num_eff = NOUT_W'(1);
        end
        else if (num_outputs_reg > NUM_OUTPUTS_MAX)
        begin
            num_eff = NUM_OUTPUTS_MAX;
        end
        else
        begin
            num_eff = num_outputs_reg;
        end
    end

    // Byte transfers stall whenever the frame queue is full.
    assign full   = fifo_full;
    assign accept = push && !fifo_full;

    pfh_parse #(
        .MAX_VLAN_TAGS   (MAX_VLAN_TAGS),
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .frame_byte (frame_byte),
        .last_byte  (last_byte),
        .rec_push   (fifo_push),
        .rec        (push_rec)
    );

    pfh_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (fifo_push),
        .wr_rec (push_rec),
        .full   (fifo_full),
        .rd_en  (fifo_pop),
        .rd_rec (pop_rec),
        .empty  (fifo_empty)
    );

    pfh_reduce u_reduce (
        .clk        (clk),
        .rst_n      (rst_n),
        .num_eff    (num_eff),
        .q_empty    (fifo_empty),
        .q_rec      (pop_rec),
        .q_pop      (fifo_pop),
        .empty      (empty),
        .pop        (pop),
        .out_port   (out_port),
        .flow_hash  (flow_hash),
        .frame_kind (frame_kind)
    );

    // Frames of these kinds carry no hash.
    assign unhashed = (frame_kind == FK_UNKNOWN) || (frame_kind == FK_TAGS);

    // Consistency checks.
    `PFH_ASSERT_NEVER(a_no_push_when_full, clk, rst_n, fifo_push && fifo_full, "queue overrun")
    `PFH_ASSERT_NEVER(a_no_pop_when_empty, clk, rst_n, fifo_pop && fifo_empty, "queue underrun")
    `PFH_ASSERT_IMPLY(a_port_range, clk, rst_n, !empty, {1'b0, out_port} < num_eff, "bad port")
    `PFH_ASSERT_IMPLY(a_hash_zero, clk, rst_n, !empty && unhashed, flow_hash == '0, "nonzero hash")

endmodule

>>> bench/packet_flow_hash_steering_top_tb.sv
// Self-checking testbench for the flow hash steering block, with a byte-level predictor.
`timescale 1ns / 1ps

module packet_flow_hash_steering_top_tb
    import pfh_pkg::*;
();

    localparam int DRAIN_CYCLES = 60;
    localparam int LIMIT_CYCLES = 500000;
    localparam int RANDOM_BYTES = 1400;

    // Kinds of entries in the stimulus feed.
    typedef enum logic [1:0] {
        FEED_BYTE,
        FEED_CFG,
        FEED_HOLD
    } feed_op_e;

    // Payload fill patterns for generated frames.
    typedef enum logic [1:0] {
        FILL_RANDOM,
        FILL_ONES,
        FILL_ZEROS
    } fill_e;

    typedef struct {
        feed_op_e          op;
        logic [BYTE_W-1:0] data;
        logic              last;
        logic [NOUT_W-1:0] cfg;
    } feed_item_t;

    typedef struct {
        logic [PORT_W-1:0] port;
        logic [HASH_W-1:0] hash;
        logic [KIND_W-1:0] kind;
    } steer_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              push = 1'b0;
    logic              full;
    logic [BYTE_W-1:0] frame_byte = '0;
    logic              last_byte = 1'b0;
    logic              empty;
    logic              pop = 1'b0;
    logic [PORT_W-1:0] out_port;
    logic [HASH_W-1:0] flow_hash;
    logic [KIND_W-1:0] frame_kind;
    logic              cfg_we = 1'b0;
    logic [NOUT_W-1:0] cfg_data = '0;

    feed_item_t    byte_feed_q[$];
    steer_result_t steer_expect_q[$];

    bit drive_en = 1'b0;
    bit in_taken = 1'b0;
    int err_count = 0;
    int cycle_count = 0;
    int stim_bytes = 0;

    // Predicted register and per-frame parser state.
    logic [NOUT_W-1:0] pr_nout;
    logic [13:0]       pr_count;
    logic [15:0]       pr_type;
    logic [L3_W-1:0]   pr_l3;
    logic [TAG_W-1:0]  pr_tags;
    logic [KIND_W-1:0] pr_kind;
    logic [HASH_W-1:0] pr_word;
    logic [HASH_W-1:0] pr_sum;

    packet_flow_hash_steering_top dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .frame_byte (frame_byte),
        .last_byte  (last_byte),
        .empty      (empty),
        .pop        (pop),
        .out_port   (out_port),
        .flow_hash  (flow_hash),
        .frame_kind (frame_kind),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data)
    );

    // Clock with a 4 ns period.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Return the parser to its start-of-frame state.
    task automatic clear_frame_state();
        pr_count = '0;
        pr_type  = '0;
        pr_l3    = L3_W'(L2_HDR_BYTES);
        pr_tags  = '0;
        pr_kind  = PK_SEEK;
        pr_word  = '0;
        pr_sum   = '0;
    endtask

    // Advance the parser by one byte at position pr_count.
    task automatic hash_frame_byte(input logic [BYTE_W-1:0] b);
        int pos;
        int off;
        pos = int'(pr_count);
        if (pr_kind == PK_SEEK)
        begin
            if (pos + 2 >= int'(pr_l3))
            begin
                pr_type = {pr_type[7:0], b};
                if (pos + 1 == int'(pr_l3))
                begin
                    if (pr_type == ETYPE_VLAN)
                    begin
                        if (int'(pr_tags) >= MAX_VLAN_TAGS_DEF)
                            pr_kind = PK_NOHASH;
                        else
                        begin
                            pr_tags = pr_tags + 1'b1;
                            pr_l3   = pr_l3 + L3_W'(VLAN_TAG_BYTES);
                        end
                    end
                    else if (pr_type == ETYPE_IPV4)
                        pr_kind = PK_V4;
                    else if (pr_type == ETYPE_IPV6)
                        pr_kind = PK_V6;
                    else
                        pr_kind = PK_NOHASH;
                end
            end
        end
        else if (pos >= int'(pr_l3))
        begin
            off = pos - int'(pr_l3);
            // IPv4 addresses are big-endian, IPv6 words are little-endian.
            if (pr_kind == PK_V4 && off >= 12 && off <= 19)
            begin
                pr_word = {pr_word[23:0], b};
                if ((off & 3) == 3)
                    pr_sum = pr_sum + pr_word;
            end
            else if (pr_kind == PK_V6 && off >= 8 && off <= 39)
            begin
                pr_word = {b, pr_word[31:8]};
                if ((off & 3) == 3)
                    pr_sum = pr_sum + pr_word;
            end
        end
    endtask

    // Predict the effect of one accepted byte; a last byte yields a result.
    task automatic steer_predict(input logic [BYTE_W-1:0] b, input logic last);
        steer_result_t r;
        int            n;
        if (int'(pr_count) < MAX_FRAME_BYTES_DEF)
        begin
            hash_frame_byte(b);
            pr_count = pr_count + 1'b1;
        end
        if (last)
        begin
            r.hash = '0;
            r.kind = FK_UNKNOWN;
            if (pr_kind == PK_V4 && int'(pr_count) >= int'(pr_l3) + V4_HDR_BYTES)
            begin
                r.hash = pr_sum;
                r.kind = FK_V4;
            end
            else if (pr_kind == PK_V6 && int'(pr_count) >= int'(pr_l3) + V6_HDR_BYTES)
            begin
                r.hash = pr_sum;
                r.kind = FK_V6;
            end
            else if (pr_kind == PK_NOHASH && pr_type == ETYPE_VLAN)
                r.kind = FK_TAGS;
            // A zero count acts as one, counts above the maximum are clamped.
            n = int'(pr_nout);
            if (n == 0)
                n = 1;
            if (n > int'(NUM_OUTPUTS_MAX))
                n = int'(NUM_OUTPUTS_MAX);
            r.port = PORT_W'(r.hash % HASH_W'(n));
            steer_expect_q.push_back(r);
            clear_frame_state();
        end
    endtask

    function automatic logic [BYTE_W-1:0] fill_byte(input fill_e fill);
        case (fill)
            FILL_ONES:  return 8'hFF;
            FILL_ZEROS: return 8'h00;
            default:    return BYTE_W'($urandom);
        endcase
    endfunction

    // Queue one frame: MAC addresses, ntags VLAN tags, the ethertype, then fill.
    task automatic add_frame(input logic [15:0] etype, input int ntags, input int len,
                             input fill_e fill);
        feed_item_t it;
        int         tag_end;
        tag_end = 12 + 4 * ntags;
        it.op  = FEED_BYTE;
        it.cfg = '0;
        for (int i = 0; i < len; i++)
        begin
            if (i >= 12 && i < tag_end)
            begin
                case ((i - 12) % 4)
                    0:       it.data = ETYPE_VLAN[15:8];
                    1:       it.data = ETYPE_VLAN[7:0];
                    default: it.data = fill_byte(fill);
                endcase
            end
            else if (i == tag_end)
                it.data = etype[15:8];
            else if (i == tag_end + 1)
                it.data = etype[7:0];
            else
                it.data = fill_byte(fill);
            it.last = (i == len - 1);
            byte_feed_q.push_back(it);
        end
        stim_bytes += len;
    endtask

    task automatic add_marker(input feed_op_e op, input logic [NOUT_W-1:0] value);
        feed_item_t it;
        it.op   = op;
        it.data = '0;
        it.last = 1'b0;
        it.cfg  = value;
        byte_feed_q.push_back(it);
    endtask

    // Stimulus, reset, and the end of the run.
    initial
    begin
        int            ntags;
        int            base;
        int            len;
        int            sel;
        int            frames;
        logic [15:0]   etype;
        logic [NOUT_W-1:0] cfg_pick [10];
        cfg_pick = '{9'd0, 9'd1, 9'd2, 9'd3, 9'd7, 9'd100, 9'd255, 9'd256, 9'd257, 9'd511};

        pr_nout = NUM_OUTPUTS_RST;
        clear_frame_state();

        // Directed frames at the reset output count.
        add_frame(ETYPE_IPV4, 0, 34, FILL_ONES);
        add_frame(ETYPE_IPV4, 0, 34, FILL_ZEROS);
        add_frame(ETYPE_IPV6, 0, 54, FILL_ONES);
        add_frame(ETYPE_IPV6, 0, 60, FILL_RANDOM);
        add_frame(ETYPE_IPV4, 0, 1, FILL_RANDOM);
        add_frame(ETYPE_IPV4, 0, 13, FILL_RANDOM);
        add_frame(ETYPE_IPV4, 0, 14, FILL_RANDOM);
        add_frame(ETYPE_IPV4, 0, 33, FILL_RANDOM);
        add_frame(ETYPE_IPV6, 0, 53, FILL_RANDOM);
        add_frame(16'h1234, 0, 40, FILL_RANDOM);
        add_frame(ETYPE_IPV4, 1, 40, FILL_RANDOM);
        add_frame(ETYPE_IPV6, 4, 80, FILL_RANDOM);
        add_frame(ETYPE_IPV4, 5, 60, FILL_RANDOM);
        add_frame(16'h88CC, 4, 40, FILL_RANDOM);

        // Output count extremes, including zero and out-of-range values.
        add_marker(FEED_CFG, 9'd0);
        add_frame(ETYPE_IPV4, 0, 40, FILL_RANDOM);
        add_marker(FEED_CFG, 9'd256);
        add_frame(ETYPE_IPV6, 0, 54, FILL_RANDOM);
        add_marker(FEED_CFG, 9'd511);
        add_frame(ETYPE_IPV4, 0, 34, FILL_ONES);
        add_marker(FEED_CFG, 9'd1);
        add_frame(ETYPE_IPV4, 0, 36, FILL_RANDOM);
        add_marker(FEED_CFG, 9'd255);
        add_frame(ETYPE_IPV6, 1, 60, FILL_RANDOM);
        add_marker(FEED_HOLD, '0);

        // Random frames, mostly well formed with random content.
        frames = 0;
        while (stim_bytes < RANDOM_BYTES)
        begin
            ntags = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
            sel = $urandom_range(0, 99);
            if (sel < 40)
                etype = ETYPE_IPV4;
            else if (sel < 75)
                etype = ETYPE_IPV6;
            else if (sel < 88)
                etype = 16'($urandom);
            else
            begin
                case ($urandom_range(0, 4))
                    0:       etype = 16'h0801;
                    1:       etype = 16'h86DC;
                    2:       etype = 16'h8101;
                    3:       etype = 16'h0000;
                    default: etype = 16'hFFFF;
                endcase
            end
            base = 14 + 4 * ntags;
            if (etype == ETYPE_IPV4)
                base += V4_HDR_BYTES;
            else if (etype == ETYPE_IPV6)
                base += V6_HDR_BYTES;
            else
                base += 2;
            if ($urandom_range(0, 9) == 0)
                len = $urandom_range(1, base);
            else
                len = base + $urandom_range(0, 8);
            add_frame(etype, ntags, len, FILL_RANDOM);
            frames++;
            if (frames % 12 == 0)
            begin
                if ($urandom_range(0, 1) == 0)
                    add_marker(FEED_CFG, cfg_pick[$urandom_range(0, 9)]);
                else
                    add_marker(FEED_CFG, NOUT_W'($urandom));
            end
            else if (frames % 17 == 0)
                add_marker(FEED_HOLD, '0);
        end

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);
        drive_en = 1'b1;

        while (byte_feed_q.size() != 0 || steer_expect_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0 && steer_expect_q.size() == 0)
            $display("PASS packet_flow_hash_steering_top");
        else
            $display("FAIL packet_flow_hash_steering_top");
        $finish;
    end

    // Sender: bursts of random length with random gaps; markers wait for quiet.
    always @(negedge clk)
    begin : byte_driver
        feed_item_t        head;
        logic              nx_push;
        logic [BYTE_W-1:0] nx_byte;
        logic              nx_last;
        logic              nx_we;
        logic [NOUT_W-1:0] nx_cfg;
        static int burst_left = 1;
        static int gap_left = 0;
        static int quiet_cycles = 0;
        if (drive_en)
        begin
            nx_push = push;
            nx_byte = frame_byte;
            nx_last = last_byte;
            nx_we   = 1'b0;
            nx_cfg  = cfg_data;
            if (in_taken)
            begin
                void'(byte_feed_q.pop_front());
                in_taken = 1'b0;
                nx_push  = 1'b0;
            end
            if (steer_expect_q.size() == 0 && empty && !nx_push)
                quiet_cycles++;
            else
                quiet_cycles = 0;
            if (!nx_push && byte_feed_q.size() != 0)
            begin
                head = byte_feed_q[0];
                if (head.op != FEED_BYTE)
                begin
                    // Register writes and holds happen only once the block is idle.
                    if (quiet_cycles >= DRAIN_CYCLES)
                    begin
                        if (head.op == FEED_CFG)
                        begin
                            nx_we  = 1'b1;
                            nx_cfg = head.cfg;
                        end
                        void'(byte_feed_q.pop_front());
                        quiet_cycles = 0;
                    end
                end
                else if (gap_left > 0)
                    gap_left--;
                else
                begin
                    nx_push = 1'b1;
                    nx_byte = head.data;
                    nx_last = head.last;
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 64);
                        case ($urandom_range(0, 7))
                            0, 1, 2, 3: gap_left = 0;
                            4, 5:       gap_left = $urandom_range(1, 3);
                            6:          gap_left = $urandom_range(4, 12);
                            default:    gap_left = $urandom_range(20, 40);
                        endcase
                    end
                end
            end
            push       <= nx_push;
            frame_byte <= nx_byte;
            last_byte  <= nx_last;
            cfg_we     <= nx_we;
            cfg_data   <= nx_cfg;
        end
    end

    // Receiver: pop pattern that switches between free flow, random, periodic and long stalls.
    always @(negedge clk)
    begin : result_sink
        logic      nx_pop;
        static int mode_left = 0;
        static int mode = 0;
        static int tick = 0;
        if (drive_en)
        begin
            if (mode_left == 0)
            begin
                mode = $urandom_range(0, 3);
                mode_left = (mode == 3) ? $urandom_range(10, 80) : $urandom_range(50, 300);
            end
            mode_left--;
            tick++;
            case (mode)
                0:       nx_pop = 1'b1;
                1:       nx_pop = 1'($urandom_range(0, 1));
                2:       nx_pop = (tick % 4 == 0);
                default: nx_pop = 1'b0;
            endcase
            pop <= nx_pop;
        end
    end

    // Monitor: predict on each input transfer, check each result transfer.
    always @(posedge clk)
    begin : result_monitor
        steer_result_t want;
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("FAIL packet_flow_hash_steering_top");
            $finish;
        end
        else if (rst_n)
        begin
            if (cfg_we)
                pr_nout = cfg_data;
            if (push && !full)
            begin
                in_taken = 1'b1;
                steer_predict(frame_byte, last_byte);
            end
            if (pop && !empty)
            begin
                if (steer_expect_q.size() == 0)
                begin
                    err_count++;
                    if (err_count <= 10)
                        $display("unexpected result: port %0d hash %h kind %0d",
                                 out_port, flow_hash, frame_kind);
                end
                else
                begin
                    want = steer_expect_q.pop_front();
                    if (out_port !== want.port || flow_hash !== want.hash ||
                        frame_kind !== want.kind)
                    begin
                        err_count++;
                        if (err_count <= 10)
                            $display("mismatch: expected port %0d hash %h kind %0d,",
                                     want.port, want.hash, want.kind,
                                     " got port %0d hash %h kind %0d",
                                     out_port, flow_hash, frame_kind);
                    end
                end
            end
        end
    end

endmodule

>>> filelist.f
+incdir+design
design/pfh_pkg.sv
design/pfh_parse.sv
design/pfh_fifo.sv
design/pfh_reduce.sv
design/packet_flow_hash_steering_top.sv
bench/packet_flow_hash_steering_top_tb.sv
